@@ rtl/core/tgd_pkg.sv @@
// tgd_pkg: shared types and constants for the touch gesture detector
// used by tgd_cfg_regs, tgd_core and touch_gesture_detector
`default_nettype none

package tgd_pkg;

  localparam int CFG_W = 16;
  localparam int IDX_W = 2;
  localparam int IN_TDATA_W = 8;
  localparam int OUT_TDATA_W = 8;

  localparam logic [IDX_W-1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [IDX_W-1:0] REG_GESTURE_WINDOW = 2'd1;
  localparam logic [IDX_W-1:0] REG_LONG_PRESS = 2'd2;
  localparam logic [IDX_W-1:0] REG_HOLD_STEP = 2'd3;

  localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd50;
  localparam logic [CFG_W-1:0] GESTURE_WINDOW_RST = 16'd400;
  localparam logic [CFG_W-1:0] LONG_PRESS_RST = 16'd800;
  localparam logic [CFG_W-1:0] HOLD_STEP_RST = 16'd100;

  localparam logic [1:0] MAX_TAPS = 2'd3;

  typedef struct packed {
    logic [CFG_W-1:0] debounce_ticks;
    logic [CFG_W-1:0] gesture_window_ticks;
    logic [CFG_W-1:0] long_press_ticks;
    logic [CFG_W-1:0] hold_step_ticks;
  } tgd_cfg_t;

  typedef struct packed {
    logic [1:0] gesture_taps;
    logic       long_press_start;
    logic       long_press_hold;
    logic       long_press_end;
    logic       pressed;
  } tgd_res_t;

endpackage

`default_nettype wire

@@ rtl/core/tgd_cfg_regs.sv @@
// tgd_cfg_regs: configuration register file of the touch gesture detector
// depends on tgd_pkg
`default_nettype none

module tgd_cfg_regs
  import tgd_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_wr_en,
  input  wire logic [IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0] cfg_wdata,
  output tgd_cfg_t              cfg
);

  tgd_cfg_t cfg_r;
  tgd_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_DEBOUNCE:       cfg_nxt.debounce_ticks       = cfg_wdata;
        REG_GESTURE_WINDOW: cfg_nxt.gesture_window_ticks = cfg_wdata;
        REG_LONG_PRESS:     cfg_nxt.long_press_ticks     = cfg_wdata;
        REG_HOLD_STEP:      cfg_nxt.hold_step_ticks      = cfg_wdata;
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ticks       <= DEBOUNCE_RST;
      cfg_r.gesture_window_ticks <= GESTURE_WINDOW_RST;
      cfg_r.long_press_ticks     <= LONG_PRESS_RST;
      cfg_r.hold_step_ticks      <= HOLD_STEP_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

@@ rtl/core/tgd_core.sv @@
// tgd_core: per-tick debounce, tap counting and long-press state update
// depends on tgd_pkg
`default_nettype none

module tgd_core
  import tgd_pkg::*;
#(
  parameter int CNT_W = 16
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     tick_en,
  input  wire logic     pin_level,
  input  wire logic     touch_blocked,
  input  wire tgd_cfg_t cfg,
  output tgd_res_t      res
);

  localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  logic             prev_raw_r, prev_raw_nxt;
  logic             stable_r, stable_nxt;
  logic [CNT_W-1:0] stable_cnt_r, stable_cnt_nxt;
  logic [1:0]       taps_r, taps_nxt;
  logic             win_run_r, win_run_nxt;
  logic [CNT_W-1:0] rel_cnt_r, rel_cnt_nxt;
  logic             long_fired_r, long_fired_nxt;
  logic             long_hold_r, long_hold_nxt;
  logic [CNT_W-1:0] press_cnt_r, press_cnt_nxt;
  logic [CNT_W-1:0] step_cnt_r, step_cnt_nxt;

  always_comb begin
    prev_raw_nxt   = prev_raw_r;
    stable_nxt     = stable_r;
    taps_nxt       = taps_r;
    win_run_nxt    = win_run_r;
    long_fired_nxt = long_fired_r;
    long_hold_nxt  = long_hold_r;
    res            = '0;

    // saturating advance
    stable_cnt_nxt = (stable_cnt_r == CNT_MAX) ? stable_cnt_r : stable_cnt_r + 1'b1;
    rel_cnt_nxt    = (rel_cnt_r == CNT_MAX) ? rel_cnt_r : rel_cnt_r + 1'b1;
    press_cnt_nxt  = (press_cnt_r == CNT_MAX) ? press_cnt_r : press_cnt_r + 1'b1;
    step_cnt_nxt   = (step_cnt_r == CNT_MAX) ? step_cnt_r : step_cnt_r + 1'b1;

    // gesture timeout runs even when blocked
    if (win_run_r && (CMP_W'(rel_cnt_nxt) >= CMP_W'(cfg.gesture_window_ticks))) begin
      res.gesture_taps = taps_r;
      taps_nxt         = '0;
      win_run_nxt      = 1'b0;
    end

    if (!touch_blocked) begin
      if (pin_level != prev_raw_r) begin
        stable_cnt_nxt = '0;
      end
      if (CMP_W'(stable_cnt_nxt) > CMP_W'(cfg.debounce_ticks)) begin
        if (pin_level != stable_r) begin
          stable_nxt = pin_level;
          if (pin_level) begin
            press_cnt_nxt  = '0;
            long_fired_nxt = 1'b0;
            long_hold_nxt  = 1'b0;
          end else if (long_fired_r) begin
            res.long_press_end = 1'b1;
            long_hold_nxt      = 1'b0;
          end else begin
            if (taps_nxt < MAX_TAPS) begin
              taps_nxt = taps_nxt + 1'b1;
            end
            rel_cnt_nxt = '0;
            win_run_nxt = 1'b1;
          end
        end
        if (stable_nxt && !long_fired_nxt &&
            (CMP_W'(press_cnt_nxt) >= CMP_W'(cfg.long_press_ticks))) begin
          long_fired_nxt       = 1'b1;
          long_hold_nxt        = 1'b1;
          taps_nxt             = '0;
          win_run_nxt          = 1'b0;
          step_cnt_nxt         = '0;
          res.long_press_start = 1'b1;
        end
        if (stable_nxt && long_hold_nxt &&
            (CMP_W'(step_cnt_nxt) >= CMP_W'(cfg.hold_step_ticks))) begin
          step_cnt_nxt        = '0;
          res.long_press_hold = 1'b1;
        end
      end
      prev_raw_nxt = pin_level;
    end

    res.pressed = stable_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_raw_r   <= 1'b0;
      stable_r     <= 1'b0;
      stable_cnt_r <= '0;
      taps_r       <= '0;
      win_run_r    <= 1'b0;
      rel_cnt_r    <= '0;
      long_fired_r <= 1'b0;
      long_hold_r  <= 1'b0;
      press_cnt_r  <= '0;
      step_cnt_r   <= '0;
    end else if (tick_en) begin
      prev_raw_r   <= prev_raw_nxt;
      stable_r     <= stable_nxt;
      stable_cnt_r <= stable_cnt_nxt;
      taps_r       <= taps_nxt;
      win_run_r    <= win_run_nxt;
      rel_cnt_r    <= rel_cnt_nxt;
      long_fired_r <= long_fired_nxt;
      long_hold_r  <= long_hold_nxt;
      press_cnt_r  <= press_cnt_nxt;
      step_cnt_r   <= step_cnt_nxt;
    end
  end

  a_end_releases: assert property (@(posedge clk) disable iff (!rst_n)
    (tick_en && res.long_press_end) |-> !res.pressed)
    else $error("long press end while still pressed");

  a_start_pressed: assert property (@(posedge clk) disable iff (!rst_n)
    (tick_en && res.long_press_start) |=> (stable_r && long_hold_r && !win_run_r))
    else $error("long press start without held state");

  a_taps_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !win_run_r |-> (taps_r == '0))
    else $error("taps pending with no gesture window");

endmodule

`default_nettype wire

@@ rtl/core/touch_gesture_detector.sv @@
// touch_gesture_detector: debounced tap, multi-tap and long-press detector
// the core result is registered on out_ when the held transaction advances
// throughput: one transaction per cycle unless out_tready stalls the output register,
// set by the single-pass state update in tgd_core; in_tready follows out_tready combinationally
// reset: synchronous active-low rst_n clears the valid flags and core state, config to defaults, no clearing pass
// depends on tgd_pkg, tgd_cfg_regs, tgd_core
`default_nettype none

module touch_gesture_detector
  import tgd_pkg::*;
#(
  parameter int TICK_COUNTER_WIDTH = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // [0] pin_level, [1] touch_blocked, [7:2] zero
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // [1:0] gesture_taps, [2] long_press_start, [3] long_press_hold,
  // [4] long_press_end, [5] pressed, [7:6] zero
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  input  wire logic                   cfg_wr_en,
  input  wire logic [IDX_W-1:0]       cfg_index,
  input  wire logic [CFG_W-1:0]       cfg_wdata
);

  tgd_cfg_t cfg;
  tgd_res_t res;

  logic     in_vld_r;
  logic     pin_r;
  logic     blocked_r;
  logic     out_vld_r;
  tgd_res_t out_res_r;
  logic     adv;

  assign adv       = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || adv;

  tgd_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  tgd_core #(
    .CNT_W (TICK_COUNTER_WIDTH)
  ) u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .tick_en       (adv),
    .pin_level     (pin_r),
    .touch_blocked (blocked_r),
    .cfg           (cfg),
    .res           (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_tready) begin
        in_vld_r <= in_tvalid;
      end
      if (adv) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      pin_r     <= in_tdata[0];
      blocked_r <= in_tdata[1];
    end
    if (adv) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {2'b00, out_res_r.pressed, out_res_r.long_press_end,
                       out_res_r.long_press_hold, out_res_r.long_press_start,
                       out_res_r.gesture_taps};

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_vld_r |-> in_tready)
    else $error("input stalled with empty output register");

  a_adv_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_vld_r)
    else $error("processed transaction not offered");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_tready) |-> !adv)
    else $error("pending result overwritten");

endmodule

`default_nettype wire
